// File: design/llts_pkg.sv
// Shared constants and controller/datapath interface types for the LLF scheduler.
package llts_pkg;

    // Fixed field widths of the request and result channels
    localparam int IN_IDX_W  = 3;
    localparam int FIELD_W   = 16;
    localparam int MASK_W    = 8;
    localparam int OUT_IDX_W = 3;

    // Request type codes
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap_in;    // latch the request fields, clear the scan state
        logic wr_set;    // write a task template and release its first job
        logic scan;      // selection pass: examine one task slot
        logic upd;       // update pass: age and reload one task slot
        logic load_out;  // move the finished result into the output register
    } llts_cmd_t;

endpackage

// File: design/llts_ctrl.sv
// Controller FSM: sequences the set write, the selection pass and the update pass.
module llts_ctrl #(
    parameter int TASK_COUNT = 8,
    parameter int IDX_W      = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    output logic                 m_valid,
    input  logic                 m_ready,
    output llts_pkg::llts_cmd_t  cmd,
    output logic [IDX_W-1:0]     slot_idx
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SET  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             in_xfer;
    logic             out_free;
    logic             last_slot;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_slot = (cnt_reg == LAST_IDX);
    assign m_valid   = m_valid_reg;
    assign slot_idx  = cnt_reg;

    // Next state, slot counter and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd.cap_in = 1'b1;
                    cnt_next   = '0;
                    state_next = (s_req_type == llts_pkg::REQ_TICK) ? ST_SCAN : ST_SET;
                end
            end
            ST_SET: begin
                cmd.wr_set = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (last_slot) begin
                    cnt_next   = '0;
                    state_next = ST_UPD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPD: begin
                cmd.upd = 1'b1;
                if (last_slot) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // wait for the output register to drain
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: design/llts_datapath.sv
// Datapath: task table, laxity compare, countdown update and result registers.
module llts_datapath #(
    parameter int TASK_COUNT = 8,
    parameter int TIME_WIDTH = 16,
    parameter int IDX_W      = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  llts_pkg::llts_cmd_t                  cmd,
    input  logic [IDX_W-1:0]                     slot_idx,
    input  logic [llts_pkg::IN_IDX_W-1:0]        s_task_index,
    input  logic [llts_pkg::FIELD_W-1:0]         s_exec_time,
    input  logic [llts_pkg::FIELD_W-1:0]         s_task_period,
    input  logic [llts_pkg::FIELD_W-1:0]         s_rel_deadline,
    output logic                                 m_run_valid,
    output logic [llts_pkg::OUT_IDX_W-1:0]       m_run_task,
    output logic [llts_pkg::MASK_W-1:0]          m_missed_mask
);

    localparam int TW = TIME_WIDTH;
    localparam int DW = TIME_WIDTH + 2;   // deadline countdown, signed
    localparam int LW = TIME_WIDTH + 3;   // laxity, signed
    localparam int FW = llts_pkg::FIELD_W;
    localparam logic signed [DW-1:0] DL_MIN = {1'b1, {(DW-1){1'b0}}};

    // Task table
    logic [TW-1:0]        exec_t_reg [TASK_COUNT];
    logic [TW-1:0]        per_t_reg  [TASK_COUNT];
    logic [TW-1:0]        dl_t_reg   [TASK_COUNT];
    logic [TW-1:0]        work_reg   [TASK_COUNT];
    logic [TW-1:0]        pc_reg     [TASK_COUNT];
    logic signed [DW-1:0] dl_reg     [TASK_COUNT];

    // Captured request
    logic [llts_pkg::IN_IDX_W-1:0] tidx_reg;
    logic [TW-1:0]                 exec_in_reg, per_in_reg, dl_in_reg;

    // Per-tick scan results
    logic                       found_reg;
    logic signed [LW-1:0]       best_reg;
    logic [IDX_W-1:0]           pick_reg;
    logic [llts_pkg::MASK_W-1:0] miss_reg;

    // Output register
    logic                          out_valid_reg;
    logic [llts_pkg::OUT_IDX_W-1:0] out_task_reg;
    logic [llts_pkg::MASK_W-1:0]    out_miss_reg;

    // Field resizing to TIME_WIDTH
    logic [TW+FW-1:0] exec_wide, per_wide, dl_wide;
    assign exec_wide = {{TW{1'b0}}, s_exec_time};
    assign per_wide  = {{TW{1'b0}}, s_task_period};
    assign dl_wide   = {{TW{1'b0}}, s_rel_deadline};

    // Set slot decode
    logic [IDX_W+llts_pkg::IN_IDX_W-1:0] set_wide;
    logic [IDX_W-1:0]                    set_slot;
    logic                                set_ok;
    assign set_wide = {{IDX_W{1'b0}}, tidx_reg};
    assign set_slot = set_wide[IDX_W-1:0];
    assign set_ok   = (set_wide < (IDX_W + llts_pkg::IN_IDX_W)'(TASK_COUNT));

    // Current slot read
    logic [TW-1:0]        cur_work, cur_pc;
    logic signed [DW-1:0] cur_dl;
    assign cur_work = work_reg[slot_idx];
    assign cur_pc   = pc_reg[slot_idx];
    assign cur_dl   = dl_reg[slot_idx];

    // Laxity compare for the selection pass
    logic signed [LW-1:0] cur_lax;
    logic                 take;
    assign cur_lax = $signed({cur_dl[DW-1], cur_dl}) - $signed({3'b000, cur_work});
    assign take    = (cur_work != '0) && (!found_reg || (cur_lax < best_reg));

    // Update pass: charge the picked task, age countdowns, detect a miss
    logic                 hit, expire;
    logic [TW-1:0]        work_dec, pc_dec;
    logic signed [DW-1:0] dl_dec;
    logic                 miss_bit;
    logic [IDX_W+2:0]     mask_wide;
    logic                 mask_ok;
    assign hit       = found_reg && (pick_reg == slot_idx);
    assign work_dec  = cur_work - TW'(hit);
    assign expire    = (cur_pc <= TW'(1));
    assign pc_dec    = (cur_pc != '0) ? cur_pc - 1'b1 : cur_pc;
    assign dl_dec    = (cur_dl != DL_MIN) ? cur_dl - 1'b1 : cur_dl;
    assign miss_bit  = (dl_dec[DW-1] || (dl_dec == '0)) && (work_dec != '0);
    assign mask_wide = {3'b000, slot_idx};
    assign mask_ok   = (mask_wide < (IDX_W + 3)'(llts_pkg::MASK_W));

    // Picked index resized to the result field
    logic [IDX_W+2:0] pick_wide;
    assign pick_wide = {3'b000, pick_reg};

    // Request capture and per-tick scan state
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            tidx_reg    <= s_task_index;
            exec_in_reg <= exec_wide[TW-1:0];
            per_in_reg  <= per_wide[TW-1:0];
            dl_in_reg   <= dl_wide[TW-1:0];
        end
        if (!aresetn) begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            pick_reg  <= '0;
            miss_reg  <= '0;
        end else if (cmd.cap_in) begin
            found_reg <= 1'b0;
            best_reg  <= '0;
            pick_reg  <= '0;
            miss_reg  <= '0;
        end else begin
            if (cmd.scan && take) begin
                found_reg <= 1'b1;
                best_reg  <= cur_lax;
                pick_reg  <= slot_idx;
            end
            if (cmd.upd && miss_bit && mask_ok) begin
                miss_reg[mask_wide[2:0]] <= 1'b1;
            end
        end
    end

    // Task table writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < TASK_COUNT; j++) begin
                exec_t_reg[j] <= '0;
                per_t_reg[j]  <= '0;
                dl_t_reg[j]   <= '0;
                work_reg[j]   <= '0;
                pc_reg[j]     <= '0;
                dl_reg[j]     <= '0;
            end
        end else if (cmd.wr_set && set_ok) begin
            exec_t_reg[set_slot] <= exec_in_reg;
            per_t_reg[set_slot]  <= per_in_reg;
            dl_t_reg[set_slot]   <= dl_in_reg;
            work_reg[set_slot]   <= exec_in_reg;
            pc_reg[set_slot]     <= per_in_reg;
            dl_reg[set_slot]     <= $signed({2'b00, dl_in_reg});
        end else if (cmd.upd) begin
            if (expire) begin
                // period over: release a fresh job
                work_reg[slot_idx] <= exec_t_reg[slot_idx];
                pc_reg[slot_idx]   <= per_t_reg[slot_idx];
                dl_reg[slot_idx]   <= $signed({2'b00, dl_t_reg[slot_idx]});
            end else begin
                work_reg[slot_idx] <= work_dec;
                pc_reg[slot_idx]   <= pc_dec;
                dl_reg[slot_idx]   <= dl_dec;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_valid_reg <= found_reg;
            out_task_reg  <= found_reg ? pick_wide[2:0] : '0;
            out_miss_reg  <= miss_reg;
        end
    end

    assign m_run_valid   = out_valid_reg;
    assign m_run_task    = out_task_reg;
    assign m_missed_mask = out_miss_reg;

endmodule

// File: design/least_laxity_task_scheduler_unit.sv
// Top level of the least-laxity-first periodic task scheduler.
//
// Input channel (s_*): one request per transfer. A set request (s_req_type 0)
// stores the template of task s_task_index and releases its first job; a tick
// request (s_req_type 1) runs the unfinished task with least laxity for one
// unit, ages every countdown and reloads expired jobs.
// Result channel (m_*): exactly one result per request. A set returns all
// zeros; a tick returns the task that ran (or run_valid 0 when idle) and the
// mask of tasks past their deadline with work left.
// Sequence: a set is captured, written to the table and then loaded into the
// output register; a tick is captured, then runs one selection pass and one
// update pass over the task table, one slot per cycle through a single read
// port, then the output load. One request is in work at a time and the input
// reopens the cycle after the load.
// Reset (aresetn low, synchronous) clears the table, the scan state, the
// controller and m_valid. The result sits in an output register: while the receiver
// stalls the next request is still taken and worked, and it waits in the
// final state until the output register drains.
module least_laxity_task_scheduler_unit #(
    parameter int TASK_COUNT = 8,
    parameter int TIME_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [llts_pkg::IN_IDX_W-1:0]    s_task_index,
    input  logic [llts_pkg::FIELD_W-1:0]     s_exec_time,
    input  logic [llts_pkg::FIELD_W-1:0]     s_task_period,
    input  logic [llts_pkg::FIELD_W-1:0]     s_rel_deadline,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_run_valid,
    output logic [llts_pkg::OUT_IDX_W-1:0]   m_run_task,
    output logic [llts_pkg::MASK_W-1:0]      m_missed_mask
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    llts_pkg::llts_cmd_t cmd;
    logic [IDX_W-1:0]    slot_idx;

    llts_ctrl #(
        .TASK_COUNT (TASK_COUNT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .slot_idx   (slot_idx)
    );

    llts_datapath #(
        .TASK_COUNT (TASK_COUNT),
        .TIME_WIDTH (TIME_WIDTH),
        .IDX_W      (IDX_W)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .slot_idx       (slot_idx),
        .s_task_index   (s_task_index),
        .s_exec_time    (s_exec_time),
        .s_task_period  (s_task_period),
        .s_rel_deadline (s_rel_deadline),
        .m_run_valid    (m_run_valid),
        .m_run_task     (m_run_task),
        .m_missed_mask  (m_missed_mask)
    );

endmodule

// File: design/llts_checker.sv
// Port-level checker for the scheduler, bound to the top level.
module llts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_run_valid,
    input logic [llts_pkg::OUT_IDX_W-1:0] m_run_task,
    input logic [llts_pkg::MASK_W-1:0]    m_missed_mask
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_run_valid, m_run_task, m_missed_mask}))
        else $error("result payload changed while stalled");

    // One request in work at a time: no back-to-back input transfers
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a request is in work");

    // An idle tick or set acknowledge reports task zero
    a_idle_task: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_valid |-> m_run_task == '0)
        else $error("nonzero run_task without a run");

    // Reset empties the result channel
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind least_laxity_task_scheduler_unit llts_checker u_llts_checker (.*);
